/* hdl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// shared types, constants and helpers of the boot region bump allocator
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int REGION_SLOTS = 128;
    localparam int IDX_W        = $clog2(REGION_SLOTS);
    localparam int PAGE_SHIFT   = 12;
    localparam int AW           = 48;
    localparam int PG_W         = 36;
    localparam int TYPE_W       = 8;
    localparam int VA_W         = 64;
    localparam int LG_W         = 6;
    localparam int ENT_W        = 2 * AW + TYPE_W;
    localparam int CFG_AW       = 5;
    localparam int CFG_DW       = 64;
    localparam int IN_W         = 160;
    localparam int OUT_W        = 144;

    localparam logic [AW-1:0]   PAGE_BYTES = AW'(1) << PAGE_SHIFT;
    localparam logic [AW-1:0]   PAGE_MASK  = PAGE_BYTES - AW'(1);
    localparam logic [PG_W-1:0] PG_MAX     = {PG_W{1'b1}};

    localparam logic [AW-1:0]     KSTART_RST  = AW'(48'h10_0000);
    localparam logic [AW-1:0]     KEND_RST    = AW'(48'h20_0000);
    localparam logic [VA_W-1:0]   DMOFF_RST   = '0;
    localparam logic [TYPE_W-1:0] RAMTYPE_RST = TYPE_W'(1);

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_NOFIT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_KSTART  = 2'd0,
        REG_KEND    = 2'd1,
        REG_DMOFF   = 2'd2,
        REG_RAMTYPE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [AW-1:0]     kstart;
        logic [AW-1:0]     kend;
        logic [VA_W-1:0]   dmoff;
        logic [TYPE_W-1:0] ram_type;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [AW-1:0]     region_start;
        logic [AW-1:0]     region_end;
        logic [TYPE_W-1:0] region_type;
        logic [AW-1:0]     alloc_size;
        logic [LG_W-1:0]   align_log2;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [VA_W-1:0]   alloc_address;
        logic [PG_W-1:0]   max_page_number;
        logic [PG_W-1:0]   allocable_page_count;
    } res_t;

    typedef struct packed {
        logic [TYPE_W-1:0] rtype;
        logic [AW-1:0]     rend;
        logic [AW-1:0]     rstart;
    } ent_t;

    function automatic logic [AW-1:0] page_up(input logic [AW-1:0] a);
        page_up = (a + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    function automatic logic [AW-1:0] page_down(input logic [AW-1:0] a);
        page_down = a & ~PAGE_MASK;
    endfunction

    // page count of a byte span, saturated to the counter width
    function automatic logic [PG_W-1:0] pages_of(input logic [AW-1:0] a);
        logic [AW-1:0] w;
        w = a >> PAGE_SHIFT;
        pages_of = (w > AW'(PG_MAX)) ? PG_MAX : PG_W'(w);
    endfunction

endpackage

/* hdl/bra_ram.sv */
// ----------------------------------------------------------------------------
// bra_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/bra_cfg.sv */
// ----------------------------------------------------------------------------
// bra_cfg
// apb register file for kernel range, direct-map offset and ram type
// ----------------------------------------------------------------------------
module bra_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bra_pkg::CFG_AW-1:0] paddr,
    input  logic [bra_pkg::CFG_DW-1:0] pwdata,
    output logic [bra_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output bra_pkg::cfg_t              cfg
);

    bra_pkg::cfg_t    cfg_reg;
    bra_pkg::reg_idx_t sel;
    logic             wr_en;

    assign sel    = bra_pkg::reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kstart   <= bra_pkg::KSTART_RST;
            cfg_reg.kend     <= bra_pkg::KEND_RST;
            cfg_reg.dmoff    <= bra_pkg::DMOFF_RST;
            cfg_reg.ram_type <= bra_pkg::RAMTYPE_RST;
        end else if (wr_en) begin
            unique case (sel)
                bra_pkg::REG_KSTART:  cfg_reg.kstart   <= pwdata[bra_pkg::AW-1:0];
                bra_pkg::REG_KEND:    cfg_reg.kend     <= pwdata[bra_pkg::AW-1:0];
                bra_pkg::REG_DMOFF:   cfg_reg.dmoff    <= pwdata;
                bra_pkg::REG_RAMTYPE: cfg_reg.ram_type <= pwdata[bra_pkg::TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            bra_pkg::REG_KSTART:  prdata = bra_pkg::CFG_DW'(cfg_reg.kstart);
            bra_pkg::REG_KEND:    prdata = bra_pkg::CFG_DW'(cfg_reg.kend);
            bra_pkg::REG_DMOFF:   prdata = cfg_reg.dmoff;
            bra_pkg::REG_RAMTYPE: prdata = bra_pkg::CFG_DW'(cfg_reg.ram_type);
            default:              prdata = '0;
        endcase
    end

endmodule

/* hdl/bra_ctrl.sv */
// ----------------------------------------------------------------------------
// bra_ctrl
// insert and first-fit allocate sequencer around the region table ram
// ----------------------------------------------------------------------------
module bra_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bra_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bra_pkg::item_t            item,
    input  logic                      out_free,
    output logic                      res_load,
    output bra_pkg::res_t             res,
    output logic                      ram_we,
    output logic [bra_pkg::IDX_W-1:0] ram_waddr,
    output bra_pkg::ent_t             ram_wdata,
    output logic [bra_pkg::IDX_W-1:0] ram_raddr,
    input  bra_pkg::ent_t             ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_PLAN, S_CNT, S_ADD, S_FREE, S_ASCAN, S_ADDR, S_RESP
    } state_t;

    localparam logic [bra_pkg::IDX_W-1:0] LAST_IDX = bra_pkg::IDX_W'(bra_pkg::REGION_SLOTS - 1);

    state_t state_reg;

    logic [bra_pkg::AW-1:0]     rs_reg, re_reg, size_reg;
    logic [bra_pkg::TYPE_W-1:0] type_reg;
    logic [bra_pkg::VA_W-1:0]   mask_reg;
    logic [bra_pkg::AW-1:0]     s_reg, e_reg;
    logic                       zs_reg;
    logic [bra_pkg::AW-1:0]     p0s_reg, p0e_reg, p1s_reg, p1e_reg;
    logic                       p0v_reg, p1v_reg, pc_reg;
    logic [bra_pkg::PG_W-1:0]   n_reg;
    logic [bra_pkg::IDX_W-1:0]  idx_reg, idx1_reg, idx2_reg;
    logic                       issue_reg, v1_reg, v2_reg;
    logic [bra_pkg::VA_W-1:0]   a2_reg, b2_reg;
    logic [bra_pkg::AW-1:0]     end2_reg;
    logic [bra_pkg::TYPE_W-1:0] type2_reg;
    logic [bra_pkg::REGION_SLOTS-1:0] valid_reg;
    logic [bra_pkg::PG_W-1:0]   highest_reg, pages_reg;
    bra_pkg::status_t           status_reg;
    logic [bra_pkg::VA_W-1:0]   addr_reg;

    logic [bra_pkg::AW-1:0]     up, cs, ce;
    logic [bra_pkg::PG_W-1:0]   pg;
    logic                       empty, in_kernel, overlap, cur_v;
    logic [bra_pkg::PG_W:0]     pages_sum;
    logic                       hit1, fit;
    logic [bra_pkg::VA_W-1:0]   a1, b1;
    logic [bra_pkg::VA_W:0]     sum2;

    assign in_ready  = aresetn && (state_reg == S_IDLE);
    assign res_load  = (state_reg == S_RESP) && out_free;
    assign res       = '{status: status_reg, alloc_address: addr_reg,
                         max_page_number: highest_reg, allocable_page_count: pages_reg};
    assign ram_raddr = idx_reg;

    always_comb begin
        up        = bra_pkg::page_up(rs_reg);
        pg        = bra_pkg::pages_of(e_reg);
        empty     = (s_reg >= e_reg);
        in_kernel = (s_reg >= cfg.kstart) && (e_reg <= cfg.kend);
        overlap   = (cfg.kstart < cfg.kend) && (s_reg < cfg.kend) && (e_reg > cfg.kstart);
        cs      = pc_reg ? p1s_reg : p0s_reg;
        ce      = pc_reg ? p1e_reg : p0e_reg;
        cur_v   = (pc_reg ? p1v_reg : p0v_reg) && (cs < ce);
        pages_sum = {1'b0, pages_reg} + {1'b0, n_reg};
        // stage one of the alloc scan: match the slot type and align the slot bounds
        hit1 = v1_reg && valid_reg[idx1_reg] && (ram_rdata.rstart != '0)
               && (ram_rdata.rtype == cfg.ram_type);
        a1   = (bra_pkg::VA_W'(ram_rdata.rstart) + mask_reg) & ~mask_reg;
        b1   = bra_pkg::VA_W'(ram_rdata.rend) & ~mask_reg;
        // stage two: span must be strictly larger than the size
        sum2 = {1'b0, a2_reg} + (bra_pkg::VA_W + 1)'(size_reg);
        fit  = v2_reg && ({1'b0, b2_reg} > sum2);
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{rtype: type_reg, rend: ce, rstart: cs};
        if (state_reg == S_FREE && !valid_reg[idx_reg]) begin
            ram_we = 1'b1;
        end else if (state_reg == S_ASCAN && fit) begin
            ram_we    = 1'b1;
            ram_waddr = idx2_reg;
            ram_wdata = '{rtype: type2_reg, rend: end2_reg,
                          rstart: sum2[bra_pkg::AW-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            highest_reg <= '0;
            pages_reg   <= '0;
            issue_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        rs_reg     <= item.region_start;
                        re_reg     <= item.region_end;
                        type_reg   <= item.region_type;
                        size_reg   <= item.alloc_size;
                        mask_reg   <= (bra_pkg::VA_W'(1) << item.align_log2)
                                      - bra_pkg::VA_W'(1);
                        status_reg <= bra_pkg::STAT_OK;
                        addr_reg   <= '0;
                        idx_reg    <= '0;
                        if (item.mode) begin
                            issue_reg <= 1'b1;
                            v1_reg    <= 1'b0;
                            v2_reg    <= 1'b0;
                            state_reg <= S_ASCAN;
                        end else begin
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    zs_reg    <= (up == '0);
                    s_reg     <= (up == '0) ? bra_pkg::PAGE_BYTES : up;
                    e_reg     <= bra_pkg::page_down(re_reg);
                    state_reg <= S_PLAN;
                end
                S_PLAN: begin
                    pc_reg <= 1'b0;
                    if (zs_reg && empty) begin
                        state_reg <= S_RESP;
                    end else begin
                        if (pg > highest_reg) begin
                            highest_reg <= pg;
                        end
                        if (empty || in_kernel) begin
                            state_reg <= S_RESP;
                        end else begin
                            if (overlap) begin
                                // keep the parts below and above the kernel image
                                p0s_reg <= s_reg;
                                p0e_reg <= bra_pkg::page_down(cfg.kstart);
                                p0v_reg <= (s_reg < cfg.kstart);
                                p1s_reg <= bra_pkg::page_up(cfg.kend);
                                p1e_reg <= e_reg;
                                p1v_reg <= (e_reg > cfg.kend);
                            end else begin
                                p0s_reg <= s_reg;
                                p0e_reg <= e_reg;
                                p0v_reg <= 1'b1;
                                p1v_reg <= 1'b0;
                            end
                            state_reg <= S_CNT;
                        end
                    end
                end
                S_CNT: begin
                    if (cur_v) begin
                        n_reg     <= bra_pkg::pages_of(ce - cs);
                        state_reg <= S_ADD;
                    end else if (!pc_reg) begin
                        pc_reg <= 1'b1;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                S_ADD: begin
                    if (type_reg == cfg.ram_type) begin
                        pages_reg <= pages_sum[bra_pkg::PG_W] ? bra_pkg::PG_MAX
                                     : pages_sum[bra_pkg::PG_W-1:0];
                    end
                    idx_reg   <= '0;
                    state_reg <= S_FREE;
                end
                S_FREE: begin
                    if (!valid_reg[idx_reg] || idx_reg == LAST_IDX) begin
                        if (!valid_reg[idx_reg]) begin
                            valid_reg[idx_reg] <= 1'b1;
                        end else begin
                            status_reg <= bra_pkg::STAT_FULL;
                        end
                        if (!pc_reg) begin
                            pc_reg    <= 1'b1;
                            state_reg <= S_CNT;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ASCAN: begin
                    if (fit) begin
                        issue_reg <= 1'b0;
                        v1_reg    <= 1'b0;
                        v2_reg    <= 1'b0;
                        state_reg <= S_ADDR;
                    end else if (!issue_reg && !v1_reg && !v2_reg) begin
                        status_reg <= bra_pkg::STAT_NOFIT;
                        state_reg  <= S_RESP;
                    end else begin
                        v1_reg   <= issue_reg;
                        idx1_reg <= idx_reg;
                        if (issue_reg) begin
                            if (idx_reg == LAST_IDX) begin
                                issue_reg <= 1'b0;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        v2_reg    <= hit1;
                        idx2_reg  <= idx1_reg;
                        a2_reg    <= a1;
                        b2_reg    <= b1;
                        end2_reg  <= ram_rdata.rend;
                        type2_reg <= ram_rdata.rtype;
                    end
                end
                S_ADDR: begin
                    addr_reg  <= a2_reg + cfg.dmoff;
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_FREE) |-> !valid_reg[ram_waddr])
        else $error("insert wrote an occupied slot");

    a_slots_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("occupied slot count dropped");

    a_pages_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (pages_reg >= $past(pages_reg)))
        else $error("ram page count dropped");

    a_alloc_hits_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_ASCAN) |-> valid_reg[ram_waddr])
        else $error("alloc updated an empty slot");
`endif

endmodule

/* hdl/boot_region_bump_allocator.sv */
// ----------------------------------------------------------------------------
// boot_region_bump_allocator
// boot-time region table with page-aligned insert and first-fit bump alloc
// ----------------------------------------------------------------------------
//  channel   dir   transfer           content
//  s_*       in    s_tvalid&s_tready  one insert or alloc item, mode in tuser
//  m_*       out   m_tvalid&m_tready  status, address, page state
//  apb       in    psel&penable&...   four config registers at 8*i
//
//  insert: page-aligns the range, splits it around the kernel and probes slots for a free entry, per piece
//  alloc: first-fit scan of the slots, one table ram read per cycle
//  one item in flight; the result waits in the output register
//  synchronous active-low reset clears the slot valid bits and counters
// ----------------------------------------------------------------------------
module boot_region_bump_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // region_start[47:0], region_end[95:48], region_type[103:96],
    // alloc_size[151:104], align_log2[157:152], zero pad
    input  logic [bra_pkg::IN_W-1:0]   s_tdata,
    // mode[0]
    input  logic                       s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], alloc_address[65:2], max_page_number[101:66],
    // allocable_page_count[137:102], zero pad
    output logic [bra_pkg::OUT_W-1:0]  m_tdata,
    // config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bra_pkg::CFG_AW-1:0] paddr,
    input  logic [bra_pkg::CFG_DW-1:0] pwdata,
    output logic [bra_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    bra_pkg::cfg_t              cfg;
    bra_pkg::item_t             item;
    bra_pkg::res_t              res;
    logic                       res_load;
    logic                       out_free;
    logic                       ram_we;
    logic [bra_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
    bra_pkg::ent_t              ram_wdata, ram_rdata;
    logic [bra_pkg::ENT_W-1:0]  ram_rbits;
    logic                       m_tvalid_reg;
    logic [bra_pkg::OUT_W-1:0]  m_tdata_reg;

    // unpack the input transfer
    assign item.mode         = s_tuser;
    assign item.region_start = s_tdata[47:0];
    assign item.region_end   = s_tdata[95:48];
    assign item.region_type  = s_tdata[103:96];
    assign item.alloc_size   = s_tdata[151:104];
    assign item.align_log2   = s_tdata[157:152];

    assign ram_rdata = bra_pkg::ent_t'(ram_rbits);

    bra_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // region table: type, end, start per slot
    bra_ram #(
        .WIDTH (bra_pkg::ENT_W),
        .DEPTH (bra_pkg::REGION_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (bra_pkg::ENT_W'(ram_wdata)),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    bra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register, free when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {6'd0, res.allocable_page_count, res.max_page_number,
                             res.alloc_address, res.status};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule
